// ===== src/sccb_pkg.sv =====
// ----------------------------------------------------------------------------
// SCCB register master package
// Command codes, byte stage codes and widths shared by the register master.
// ----------------------------------------------------------------------------
package sccb_pkg;

   // Command field of an input transaction.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Which byte of the bus transfer is in flight.
   typedef enum logic [2:0] {
      STAGE_WR_ADDR = 3'd0,
      STAGE_REG_IDX = 3'd1,
      STAGE_DATA    = 3'd2,
      STAGE_RD_ADDR = 3'd3,
      STAGE_RD_DATA = 3'd4,
      STAGE_FAIL    = 3'd7
   } stage_type;

   // Configuration register indexes.
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_PHASE_TICKS    = 1'b1;

   localparam int unsigned ADDR_W  = 7;
   localparam int unsigned TICKS_W = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned BITS_W  = 4;

   localparam logic [ADDR_W-1:0]  DEVICE_ADDRESS_RESET = 7'd33;
   localparam logic [TICKS_W-1:0] PHASE_TICKS_RESET    = 16'd50;
   localparam logic [BITS_W-1:0]  BITS_PER_BYTE        = 4'd8;

endpackage

// ===== src/sccb_register_master.sv =====
// ----------------------------------------------------------------------------
// SCCB register master
// Drives the clock and data lines of a three-phase write / two-phase read
// register access, one waveform tick per input transaction.
// ----------------------------------------------------------------------------
// Usage: every input transaction (req_*) is one tick of the bus waveform. A
// write or read command received while idle latches its operands and starts
// a bus transfer; while a transfer is running every transaction, whatever its
// command, advances the waveform by one tick and req_sda_in is the level of
// the data line sampled during that tick. Each half-bit phase lasts
// phase_ticks ticks (zero acts as one).
// Every input transaction yields exactly one result transaction (rsp_*) with
// the line levels to drive, the busy flag, and on the final tick the done
// flag, the success flag and, after a good read, the byte read.
// The result is registered and appears in the cycle after acceptance. The
// state update and the result are computed in one pass of logic between the
// state registers and the result register, so one transaction is accepted
// every clock cycle while req_stall is low. When the receiver stalls with a
// result still held, req_stall rises and the block waits; it resumes as soon
// as the result is taken. Reset returns to idle with both lines released
// high, device address 33 and 50 ticks per phase. The configuration port
// writes a register; users must use it only while idle (block does not check).
// ----------------------------------------------------------------------------
module sccb_register_master (
   input  logic        clock,
   input  logic        reset,
   // Configuration write port
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   // Input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_reg_address,
   input  logic [7:0]  req_reg_value,
   input  logic        req_sda_in,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_level,
   output logic        rsp_sda_release,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_success,
   output logic [7:0]  rsp_read_byte
);

   // Waveform phases.
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ST_A,
      PH_ST_B,
      PH_ST_C,
      PH_WB_LO,
      PH_WB_HI,
      PH_ACK_LO,
      PH_ACK_HI,
      PH_RB_LO,
      PH_RB_HI,
      PH_NA_LO,
      PH_NA_HI,
      PH_SP_A,
      PH_SP_B,
      PH_SP_C
   } phase_type;

   // Configuration registers.
   logic [sccb_pkg::ADDR_W-1:0]  device_address_ff;
   logic [sccb_pkg::TICKS_W-1:0] phase_ticks_ff;

   // Sequencer state.
   phase_type                    phase_ff, phase_in;
   sccb_pkg::stage_type          stage_ff, stage_in;
   logic [sccb_pkg::BITS_W-1:0]  bit_count_ff, bit_count_in;
   logic [sccb_pkg::TICKS_W-1:0] tick_count_ff, tick_count_in;
   logic [sccb_pkg::BYTE_W-1:0]  shift_byte_ff, shift_byte_in;
   logic [sccb_pkg::BYTE_W-1:0]  held_address_ff, held_address_in;
   logic [sccb_pkg::BYTE_W-1:0]  held_value_ff, held_value_in;
   logic [sccb_pkg::BYTE_W-1:0]  gathered_byte_ff, gathered_byte_in;
   logic                         is_read_ff, is_read_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         scl_ff, scl_in;
   logic                         sda_ff, sda_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic                         success_ff, success_in;
   logic [sccb_pkg::BYTE_W-1:0]  read_byte_ff, read_byte_in;

   logic                         req_accept;
   logic [sccb_pkg::TICKS_W-1:0] tick_limit;
   logic [sccb_pkg::TICKS_W-1:0] tick_next;
   logic                         phase_end;
   logic [sccb_pkg::BYTE_W-1:0]  write_byte;
   logic [sccb_pkg::BYTE_W-1:0]  read_addr_byte;
   logic [sccb_pkg::BITS_W-1:0]  bit_count_inc;

   // The input waits only while a result is held and the receiver stalls.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // Tick counting; a zero phase length behaves as one.
   assign tick_limit     = (phase_ticks_ff == '0) ? {{(sccb_pkg::TICKS_W-1){1'b0}}, 1'b1}
                                                  : phase_ticks_ff;
   assign tick_next      = tick_count_ff + {{(sccb_pkg::TICKS_W-1){1'b0}}, 1'b1};
   assign phase_end      = (tick_next >= tick_limit);
   assign write_byte     = {device_address_ff, 1'b0};
   assign read_addr_byte = {device_address_ff, 1'b1};
   assign bit_count_inc  = bit_count_ff + {{(sccb_pkg::BITS_W-1){1'b0}}, 1'b1};

   // Next sequencer state for the transaction being accepted.
   always_comb begin
      phase_in         = phase_ff;
      stage_in         = stage_ff;
      bit_count_in     = bit_count_ff;
      tick_count_in    = tick_count_ff;
      shift_byte_in    = shift_byte_ff;
      held_address_in  = held_address_ff;
      held_value_in    = held_value_ff;
      gathered_byte_in = gathered_byte_ff;
      is_read_in       = is_read_ff;
      done_in          = 1'b0;
      success_in       = 1'b0;
      read_byte_in     = '0;

      if (phase_ff == PH_IDLE) begin
         // A start command latches its operands; anything else is ignored.
         if (req_command == sccb_pkg::CMD_WRITE || req_command == sccb_pkg::CMD_READ) begin
            held_address_in  = req_reg_address;
            held_value_in    = req_reg_value;
            is_read_in       = (req_command == sccb_pkg::CMD_READ);
            stage_in         = sccb_pkg::STAGE_WR_ADDR;
            bit_count_in     = '0;
            gathered_byte_in = '0;
            tick_count_in    = '0;
            phase_in         = PH_ST_A;
         end
      end else begin
         tick_count_in = tick_next;
         if (phase_end) begin
            tick_count_in = '0;
            unique case (phase_ff)
               PH_ST_A: phase_in = PH_ST_B;
               PH_ST_B: phase_in = PH_ST_C;
               PH_ST_C: begin
                  // Load the byte that the current stage sends.
                  bit_count_in = '0;
                  phase_in     = PH_WB_LO;
                  unique case (stage_ff)
                     sccb_pkg::STAGE_WR_ADDR: shift_byte_in = write_byte;
                     sccb_pkg::STAGE_REG_IDX: shift_byte_in = held_address_ff;
                     sccb_pkg::STAGE_DATA:    shift_byte_in = held_value_ff;
                     default:                 shift_byte_in = read_addr_byte;
                  endcase
               end
               PH_WB_LO: phase_in = PH_WB_HI;
               PH_WB_HI: begin
                  shift_byte_in = {shift_byte_ff[sccb_pkg::BYTE_W-2:0], 1'b0};
                  bit_count_in  = bit_count_inc;
                  phase_in      = (bit_count_inc >= sccb_pkg::BITS_PER_BYTE) ? PH_ACK_LO
                                                                             : PH_WB_LO;
               end
               PH_ACK_LO: phase_in = PH_ACK_HI;
               PH_ACK_HI: begin
                  // A high acknowledge aborts with a stop condition.
                  if (req_sda_in) begin
                     stage_in = sccb_pkg::STAGE_FAIL;
                     phase_in = PH_SP_A;
                  end else begin
                     unique case (stage_ff)
                        sccb_pkg::STAGE_WR_ADDR: begin
                           stage_in      = sccb_pkg::STAGE_REG_IDX;
                           bit_count_in  = '0;
                           shift_byte_in = held_address_ff;
                           phase_in      = PH_WB_LO;
                        end
                        sccb_pkg::STAGE_REG_IDX: begin
                           if (is_read_ff) begin
                              phase_in = PH_SP_A;
                           end else begin
                              stage_in      = sccb_pkg::STAGE_DATA;
                              bit_count_in  = '0;
                              shift_byte_in = held_value_ff;
                              phase_in      = PH_WB_LO;
                           end
                        end
                        sccb_pkg::STAGE_DATA: phase_in = PH_SP_A;
                        sccb_pkg::STAGE_RD_ADDR: begin
                           stage_in         = sccb_pkg::STAGE_RD_DATA;
                           bit_count_in     = '0;
                           gathered_byte_in = '0;
                           phase_in         = PH_RB_LO;
                        end
                        default: begin
                           stage_in = sccb_pkg::STAGE_FAIL;
                           phase_in = PH_SP_A;
                        end
                     endcase
                  end
               end
               PH_RB_LO: phase_in = PH_RB_HI;
               PH_RB_HI: begin
                  gathered_byte_in = {gathered_byte_ff[sccb_pkg::BYTE_W-2:0], req_sda_in};
                  bit_count_in     = bit_count_inc;
                  phase_in         = (bit_count_inc >= sccb_pkg::BITS_PER_BYTE) ? PH_NA_LO
                                                                                : PH_RB_LO;
               end
               PH_NA_LO: phase_in = PH_NA_HI;
               PH_NA_HI: phase_in = PH_SP_A;
               PH_SP_A:  phase_in = PH_SP_B;
               PH_SP_B:  phase_in = PH_SP_C;
               PH_SP_C: begin
                  // After the register index of a read, restart for the data.
                  if (stage_ff == sccb_pkg::STAGE_REG_IDX && is_read_ff) begin
                     stage_in = sccb_pkg::STAGE_RD_ADDR;
                     phase_in = PH_ST_A;
                  end else begin
                     done_in    = 1'b1;
                     success_in = (stage_ff != sccb_pkg::STAGE_FAIL);
                     if (success_in && is_read_ff) begin
                        read_byte_in = gathered_byte_ff;
                     end
                     phase_in = PH_IDLE;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // Line levels follow from the phase entered and the bit being sent.
   always_comb begin
      unique case (phase_in)
         PH_ST_A:   begin scl_in = 1'b1; sda_in = 1'b1; end
         PH_ST_B:   begin scl_in = 1'b1; sda_in = 1'b0; end
         PH_ST_C:   begin scl_in = 1'b0; sda_in = 1'b0; end
         PH_WB_LO:  begin scl_in = 1'b0; sda_in = shift_byte_in[sccb_pkg::BYTE_W-1]; end
         PH_WB_HI:  begin scl_in = 1'b1; sda_in = shift_byte_in[sccb_pkg::BYTE_W-1]; end
         PH_ACK_LO, PH_RB_LO, PH_NA_LO: begin scl_in = 1'b0; sda_in = 1'b1; end
         PH_ACK_HI, PH_RB_HI, PH_NA_HI: begin scl_in = 1'b1; sda_in = 1'b1; end
         PH_SP_A:   begin scl_in = 1'b0; sda_in = 1'b0; end
         PH_SP_B:   begin scl_in = 1'b1; sda_in = 1'b0; end
         default:   begin scl_in = 1'b1; sda_in = 1'b1; end
      endcase
      busy_in = (phase_in != PH_IDLE);
   end

   // Result register holds until taken; a new result replaces it on accept.
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state, result register and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= sccb_pkg::DEVICE_ADDRESS_RESET;
         phase_ticks_ff    <= sccb_pkg::PHASE_TICKS_RESET;
         phase_ff          <= PH_IDLE;
         stage_ff          <= sccb_pkg::STAGE_WR_ADDR;
         bit_count_ff      <= '0;
         tick_count_ff     <= '0;
         shift_byte_ff     <= '0;
         held_address_ff   <= '0;
         held_value_ff     <= '0;
         gathered_byte_ff  <= '0;
         is_read_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         scl_ff            <= 1'b1;
         sda_ff            <= 1'b1;
         busy_ff           <= 1'b0;
         done_ff           <= 1'b0;
         success_ff        <= 1'b0;
         read_byte_ff      <= '0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               sccb_pkg::CSR_DEVICE_ADDRESS:
                  device_address_ff <= csr_wdata[sccb_pkg::ADDR_W-1:0];
               sccb_pkg::CSR_PHASE_TICKS:
                  phase_ticks_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_accept) begin
            phase_ff         <= phase_in;
            stage_ff         <= stage_in;
            bit_count_ff     <= bit_count_in;
            tick_count_ff    <= tick_count_in;
            shift_byte_ff    <= shift_byte_in;
            held_address_ff  <= held_address_in;
            held_value_ff    <= held_value_in;
            gathered_byte_ff <= gathered_byte_in;
            is_read_ff       <= is_read_in;
            scl_ff           <= scl_in;
            sda_ff           <= sda_in;
            busy_ff          <= busy_in;
            done_ff          <= done_in;
            success_ff       <= success_in;
            read_byte_ff     <= read_byte_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_level   = scl_ff;
   assign rsp_sda_release = sda_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_success     = success_ff;
   assign rsp_read_byte   = read_byte_ff;

`ifndef SYNTHESIS
   // A finished transaction leaves the master idle.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> !busy_ff)
      else $error("done reported while still busy");

   // Success is only reported with done.
   a_success_with_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && success_ff) |-> done_ff)
      else $error("success without done");

   // A read byte only appears on a successful finish.
   a_read_byte_on_success: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && read_byte_ff != '0) |-> success_ff)
      else $error("read byte without success");

   // The tick counter rests at zero while idle.
   a_idle_tick_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_count_ff == '0))
      else $error("tick counter running while idle");

   // The bit counter never passes one byte.
   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= sccb_pkg::BITS_PER_BYTE)
      else $error("bit counter out of range");
`endif

endmodule
